FILE: rtl/rbsd_pkg.sv
// Shared number format, configuration register indexes and slab types for
// the ray against box slab unit. No dependencies.
package rbsd_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;

   // Difference of two coordinates needs one extra bit.
   localparam int DIFF_W      = COORD_WIDTH + 1;
   // Magnitude of the difference scaled by 2^FRAC_BITS.
   localparam int NUM_W       = DIFF_W + FRAC_BITS;
   // One quotient bit is resolved per divider stage.
   localparam int DIV_STAGES  = NUM_W;
   // Front stage, divider, saturation stage, ordering stage.
   localparam int AXIS_LAT    = DIV_STAGES + 3;

   localparam int CSR_INDEX_W = 3;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic [CSR_INDEX_W-1:0]        csr_index_type;

   localparam coord_type Q_MAX       = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam coord_type Q_MIN       = {1'b1, {(COORD_WIDTH-1){1'b0}}};
   localparam coord_type Q_ZERO      = '0;
   localparam coord_type Q_MINUS_ONE = coord_type'(-(longint'(1) << FRAC_BITS));

   localparam csr_index_type CSR_ORIGIN_X = 3'd0;
   localparam csr_index_type CSR_ORIGIN_Y = 3'd1;
   localparam csr_index_type CSR_ORIGIN_Z = 3'd2;
   localparam csr_index_type CSR_DIR_X    = 3'd3;
   localparam csr_index_type CSR_DIR_Y    = 3'd4;
   localparam csr_index_type CSR_DIR_Z    = 3'd5;

   // Ordered slab interval of one axis; ok is low when a parallel ray
   // lies outside the slab.
   typedef struct packed {
      logic      ok;
      coord_type lo;
      coord_type hi;
   } slab_type;

endpackage

FILE: rtl/rbsd_div_pipe.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on rbsd_pkg for the widths.
module rbsd_div_pipe
   import rbsd_pkg::*;
(
   input  logic                   clock,
   input  logic                   enable,
   input  logic [NUM_W-1:0]       num_in,
   input  logic                   neg_in,
   input  logic [COORD_WIDTH-1:0] den,
   output logic [NUM_W-1:0]       quo_out,
   output logic                   neg_out
);

   // Numerator bits shift out at the top while quotient bits enter below.
   logic [NUM_W-1:0]       nq_ff  [DIV_STAGES];
   logic [COORD_WIDTH-1:0] rem_ff [DIV_STAGES];
   logic                   neg_ff [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      logic [NUM_W-1:0]       nq_cur;
      logic [COORD_WIDTH-1:0] rem_cur;
      logic                   neg_cur;
      logic [COORD_WIDTH:0]   trial;
      logic [COORD_WIDTH:0]   sub;
      logic                   ge;
      logic [NUM_W-1:0]       nq_in;
      logic [COORD_WIDTH-1:0] rem_in;

      if (s == 0) begin : g_first
         assign nq_cur  = num_in;
         assign rem_cur = '0;
         assign neg_cur = neg_in;
      end else begin : g_next
         assign nq_cur  = nq_ff[s-1];
         assign rem_cur = rem_ff[s-1];
         assign neg_cur = neg_ff[s-1];
      end

      assign trial  = {rem_cur, nq_cur[NUM_W-1]};
      assign sub    = trial - {1'b0, den};
      assign ge     = ~sub[COORD_WIDTH];
      assign rem_in = ge ? sub[COORD_WIDTH-1:0] : trial[COORD_WIDTH-1:0];
      assign nq_in  = {nq_cur[NUM_W-2:0], ge};

      always_ff @(posedge clock) begin
         if (enable) begin
            nq_ff[s]  <= nq_in;
            rem_ff[s] <= rem_in;
            neg_ff[s] <= neg_cur;
         end
      end
   end

   assign quo_out = nq_ff[DIV_STAGES-1];
   assign neg_out = neg_ff[DIV_STAGES-1];

endmodule

FILE: rtl/rbsd_axis.sv
// One axis of the slab test: differences, two pipelined divisions,
// saturation and ordering. Depends on rbsd_pkg and rbsd_div_pipe.
module rbsd_axis
   import rbsd_pkg::*;
(
   input  logic      clock,
   input  logic      enable,
   input  coord_type bound_min,
   input  coord_type bound_max,
   input  coord_type origin,
   input  coord_type dir,
   output slab_type  slab_out
);

   logic signed [DIFF_W-1:0] diff_lo;
   logic signed [DIFF_W-1:0] diff_hi;
   logic [DIFF_W-1:0]        mag_lo;
   logic [DIFF_W-1:0]        mag_hi;
   logic [COORD_WIDTH-1:0]   dir_mag;
   logic                     dir_neg;

   logic [NUM_W-1:0]         num_lo_ff, num_lo_in;
   logic [NUM_W-1:0]         num_hi_ff, num_hi_in;
   logic                     neg_lo_ff, neg_lo_in;
   logic                     neg_hi_ff, neg_hi_in;
   logic                     par_ff,    par_in;
   logic                     pok_ff,    pok_in;

   logic [NUM_W-1:0]         quo_lo, quo_hi;
   logic                     qneg_lo, qneg_hi;

   logic                     par_line_ff [DIV_STAGES];
   logic                     pok_line_ff [DIV_STAGES];

   coord_type                a_ff, a_in;
   coord_type                b_ff, b_in;
   logic                     spar_ff, spok_ff;
   slab_type                 slab_ff, slab_in;

   function automatic coord_type sat_q(input logic [NUM_W-1:0] q, input logic neg);
      logic [NUM_W-1:0] lim;
      coord_type        r;
      lim = NUM_W'(Q_MAX);
      if (neg) begin
         if (q > lim + NUM_W'(1)) r = Q_MIN;
         else                     r = coord_type'(-q);
      end else begin
         if (q > lim) r = Q_MAX;
         else         r = coord_type'(q);
      end
      return r;
   endfunction

   // Front stage.
   assign diff_lo = DIFF_W'(bound_min) - DIFF_W'(origin);
   assign diff_hi = DIFF_W'(bound_max) - DIFF_W'(origin);
   assign mag_lo  = diff_lo[DIFF_W-1] ? DIFF_W'(-diff_lo) : DIFF_W'(diff_lo);
   assign mag_hi  = diff_hi[DIFF_W-1] ? DIFF_W'(-diff_hi) : DIFF_W'(diff_hi);
   assign dir_neg = dir[COORD_WIDTH-1];
   assign dir_mag = dir_neg ? COORD_WIDTH'(-dir) : COORD_WIDTH'(dir);

   assign num_lo_in = {mag_lo, {FRAC_BITS{1'b0}}};
   assign num_hi_in = {mag_hi, {FRAC_BITS{1'b0}}};
   assign neg_lo_in = diff_lo[DIFF_W-1] ^ dir_neg;
   assign neg_hi_in = diff_hi[DIFF_W-1] ^ dir_neg;
   assign par_in    = (dir == Q_ZERO);
   assign pok_in    = (origin >= bound_min) && (origin <= bound_max);

   always_ff @(posedge clock) begin
      if (enable) begin
         num_lo_ff <= num_lo_in;
         num_hi_ff <= num_hi_in;
         neg_lo_ff <= neg_lo_in;
         neg_hi_ff <= neg_hi_in;
         par_ff    <= par_in;
         pok_ff    <= pok_in;
      end
   end

   rbsd_div_pipe u_div_lo (
      .clock   (clock),
      .enable  (enable),
      .num_in  (num_lo_ff),
      .neg_in  (neg_lo_ff),
      .den     (dir_mag),
      .quo_out (quo_lo),
      .neg_out (qneg_lo)
   );

   rbsd_div_pipe u_div_hi (
      .clock   (clock),
      .enable  (enable),
      .num_in  (num_hi_ff),
      .neg_in  (neg_hi_ff),
      .den     (dir_mag),
      .quo_out (quo_hi),
      .neg_out (qneg_hi)
   );

   // Parallel-axis flags travel alongside the divider.
   always_ff @(posedge clock) begin
      if (enable) begin
         par_line_ff[0] <= par_ff;
         pok_line_ff[0] <= pok_ff;
         for (int i = 1; i < DIV_STAGES; i++) begin
            par_line_ff[i] <= par_line_ff[i-1];
            pok_line_ff[i] <= pok_line_ff[i-1];
         end
      end
   end

   // Saturation stage.
   assign a_in = sat_q(quo_lo, qneg_lo);
   assign b_in = sat_q(quo_hi, qneg_hi);

   always_ff @(posedge clock) begin
      if (enable) begin
         a_ff    <= a_in;
         b_ff    <= b_in;
         spar_ff <= par_line_ff[DIV_STAGES-1];
         spok_ff <= pok_line_ff[DIV_STAGES-1];
      end
   end

   // Ordering stage; a parallel axis leaves the interval unchanged.
   always_comb begin
      if (spar_ff) begin
         slab_in.ok = spok_ff;
         slab_in.lo = Q_MIN;
         slab_in.hi = Q_MAX;
      end else if (a_ff > b_ff) begin
         slab_in.ok = 1'b1;
         slab_in.lo = b_ff;
         slab_in.hi = a_ff;
      end else begin
         slab_in.ok = 1'b1;
         slab_in.lo = a_ff;
         slab_in.hi = b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         slab_ff <= slab_in;
      end
   end

   assign slab_out = slab_ff;

endmodule

FILE: rtl/ray_box_slab_distance_unit.sv
// Top level of the ray against axis-aligned box slab unit.
// Depends on rbsd_pkg and rbsd_axis.
//
// Usage: the ray is loaded through the csr_ channel, one register per beat
// (index 0 to 2 origin x, y, z; 3 to 5 direction x, y, z; signed Q16.16).
// csr_ready is always high and writes to other indexes are dropped. The ray
// must only be changed while no box is in flight.
// Boxes arrive on the req_ channel, one box per beat, and each produces
// exactly one beat on the rsp_ channel: rsp_hit and rsp_hit_distance, the
// entry parameter or minus one on a miss.
// Throughput is one box per cycle while req_stall is low. Each box passes
// the axis front, divider, saturation and ordering stages, then reduction
// and output registers; the divider resolves one quotient bit per stage.
// Reset clears the ray registers to zero and empties the pipeline.
// When the receiver stalls, the waiting result is parked in a one-entry
// skid register and the pipeline takes one more step, so a box can still
// be accepted; while the skid register is occupied the whole pipeline
// holds and req_stall is high. Nothing is lost or repeated.
module ray_box_slab_distance_unit
   import rbsd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,

   input  logic          req_valid,
   output logic          req_stall,
   input  coord_type     req_box_min_x,
   input  coord_type     req_box_min_y,
   input  coord_type     req_box_min_z,
   input  coord_type     req_box_max_x,
   input  coord_type     req_box_max_y,
   input  coord_type     req_box_max_z,

   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic          rsp_hit,
   output coord_type     rsp_hit_distance,

   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  coord_type     csr_data
);

   coord_type origin_x_ff, origin_y_ff, origin_z_ff;
   coord_type dir_x_ff, dir_y_ff, dir_z_ff;

   logic      enable;
   logic      vld_line_ff [AXIS_LAT];
   slab_type  slab_x, slab_y, slab_z;

   logic      red_vld_ff;
   logic      red_ok_ff,    red_ok_in;
   coord_type red_entry_ff, red_entry_in;
   coord_type red_exit_ff,  red_exit_in;

   logic      out_vld_ff;
   logic      out_hit_ff,   out_hit_in;
   coord_type out_dist_ff,  out_dist_in;

   logic      skid_full_ff;
   logic      skid_hit_ff;
   coord_type skid_dist_ff;

   // Ray registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= Q_ZERO;
         origin_y_ff <= Q_ZERO;
         origin_z_ff <= Q_ZERO;
         dir_x_ff    <= Q_ZERO;
         dir_y_ff    <= Q_ZERO;
         dir_z_ff    <= Q_ZERO;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ORIGIN_X: origin_x_ff <= csr_data;
            CSR_ORIGIN_Y: origin_y_ff <= csr_data;
            CSR_ORIGIN_Z: origin_z_ff <= csr_data;
            CSR_DIR_X:    dir_x_ff    <= csr_data;
            CSR_DIR_Y:    dir_y_ff    <= csr_data;
            CSR_DIR_Z:    dir_z_ff    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // The pipeline moves as one whenever the skid register is free.
   assign enable    = ~skid_full_ff;
   assign req_stall = skid_full_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXIS_LAT; i++) begin
            vld_line_ff[i] <= 1'b0;
         end
      end else if (enable) begin
         vld_line_ff[0] <= req_valid;
         for (int i = 1; i < AXIS_LAT; i++) begin
            vld_line_ff[i] <= vld_line_ff[i-1];
         end
      end
   end

   rbsd_axis u_axis_x (
      .clock     (clock),
      .enable    (enable),
      .bound_min (req_box_min_x),
      .bound_max (req_box_max_x),
      .origin    (origin_x_ff),
      .dir       (dir_x_ff),
      .slab_out  (slab_x)
   );

   rbsd_axis u_axis_y (
      .clock     (clock),
      .enable    (enable),
      .bound_min (req_box_min_y),
      .bound_max (req_box_max_y),
      .origin    (origin_y_ff),
      .dir       (dir_y_ff),
      .slab_out  (slab_y)
   );

   rbsd_axis u_axis_z (
      .clock     (clock),
      .enable    (enable),
      .bound_min (req_box_min_z),
      .bound_max (req_box_max_z),
      .origin    (origin_z_ff),
      .dir       (dir_z_ff),
      .slab_out  (slab_z)
   );

   // Narrowing only ever tightens the interval, so testing entry against
   // exit once after all three axes gives the same answer as testing after
   // each axis.
   always_comb begin
      red_entry_in = Q_ZERO;
      if (slab_x.lo > red_entry_in) red_entry_in = slab_x.lo;
      if (slab_y.lo > red_entry_in) red_entry_in = slab_y.lo;
      if (slab_z.lo > red_entry_in) red_entry_in = slab_z.lo;
      red_exit_in = Q_MAX;
      if (slab_x.hi < red_exit_in) red_exit_in = slab_x.hi;
      if (slab_y.hi < red_exit_in) red_exit_in = slab_y.hi;
      if (slab_z.hi < red_exit_in) red_exit_in = slab_z.hi;
      red_ok_in = slab_x.ok & slab_y.ok & slab_z.ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_vld_ff <= 1'b0;
      end else if (enable) begin
         red_vld_ff <= vld_line_ff[AXIS_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         red_ok_ff    <= red_ok_in;
         red_entry_ff <= red_entry_in;
         red_exit_ff  <= red_exit_in;
      end
   end

   // Final decision; touching intervals count as a hit.
   assign out_hit_in  = red_ok_ff && (red_entry_ff <= red_exit_ff);
   assign out_dist_in = out_hit_in ? red_entry_ff : Q_MINUS_ONE;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (enable) begin
         out_vld_ff <= red_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         out_hit_ff  <= out_hit_in;
         out_dist_ff <= out_dist_in;
      end
   end

   // Skid register: catches a stalled result so the pipeline may step once.
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_full_ff <= 1'b0;
      end else if (skid_full_ff) begin
         if (!rsp_stall) begin
            skid_full_ff <= 1'b0;
         end
      end else if (out_vld_ff && rsp_stall) begin
         skid_full_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_full_ff && out_vld_ff && rsp_stall) begin
         skid_hit_ff  <= out_hit_ff;
         skid_dist_ff <= out_dist_ff;
      end
   end

   assign rsp_valid        = skid_full_ff | out_vld_ff;
   assign rsp_hit          = skid_full_ff ? skid_hit_ff  : out_hit_ff;
   assign rsp_hit_distance = skid_full_ff ? skid_dist_ff : out_dist_ff;

endmodule
